FILE: design/sfb_pkg.sv
package sfb_pkg;

    // Payload length bits kept from a start word
    localparam int LEN_WIDTH = 16;

    // Longest burst: five header bytes plus three trailer bytes
    localparam int MAX_BURST = 8;
    localparam int CNT_W     = $clog2(MAX_BURST + 1);

    // CRC-16/KERMIT, reflected form
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W = 2;
    localparam logic [1:0]  CFG_SYNC  = 2'd0;
    localparam logic [1:0]  CFG_START = 2'd1;
    localparam logic [1:0]  CFG_END   = 2'd2;

    // Reset values of the framing bytes
    localparam logic [7:0] SYNC_RST  = 8'hFF;
    localparam logic [7:0] START_RST = 8'h02;
    localparam logic [7:0] END_RST   = 8'h03;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } t_cfg;

    // One input word's worth of output bytes, element 0 goes out first
    typedef struct packed {
        logic [MAX_BURST-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      has_end;
    } t_burst;

endpackage

FILE: design/sfb_cfg_regs.sv
module sfb_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    output logic                          o_cfg_ready,
    output sfb_pkg::t_cfg                 o_cfg
);
    import sfb_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte  <= SYNC_RST;
            r_cfg.start_byte <= START_RST;
            r_cfg.end_byte   <= END_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC:  r_cfg.sync_byte  <= i_cfg_data;
                CFG_START: r_cfg.start_byte <= i_cfg_data;
                CFG_END:   r_cfg.end_byte   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: design/sfb_framer.sv
module sfb_framer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_cmd,
    input  logic [7:0]     i_msg_code,
    input  logic [15:0]    i_payload_len,
    input  logic [7:0]     i_data_byte,
    input  sfb_pkg::t_cfg  i_cfg,
    output sfb_pkg::t_burst o_burst
);
    import sfb_pkg::*;

    // Byte-wide CRC update, one shift per bit
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [15:0]          r_crc, n_crc;
    logic [LEN_WIDTH-1:0] r_left, n_left;
    logic                 r_open, n_open;

    logic [15:0]          w_len;
    logic [15:0]          w_crc_hdr;
    logic [15:0]          w_crc_dat;
    logic [LEN_WIDTH-1:0] w_left_dec;

    assign w_len      = 16'(i_payload_len[LEN_WIDTH-1:0]);
    assign w_crc_hdr  = crc_feed(crc_feed(crc_feed(CRC_INIT, i_msg_code), w_len[15:8]),
                                 w_len[7:0]);
    assign w_crc_dat  = crc_feed(r_crc, i_data_byte);
    assign w_left_dec = (r_left != '0) ? (r_left - LEN_WIDTH'(1)) : r_left;

    // Burst contents and next frame state for the offered word
    always_comb begin
        o_burst = '0;
        n_crc   = r_crc;
        n_left  = r_left;
        n_open  = r_open;
        if (i_cmd == CMD_START) begin
            o_burst.bytes[0] = i_cfg.sync_byte;
            o_burst.bytes[1] = i_cfg.start_byte;
            o_burst.bytes[2] = i_msg_code;
            o_burst.bytes[3] = w_len[15:8];
            o_burst.bytes[4] = w_len[7:0];
            if (w_len == '0) begin
                // empty payload: trailer right behind the header
                o_burst.bytes[5] = w_crc_hdr[15:8];
                o_burst.bytes[6] = w_crc_hdr[7:0];
                o_burst.bytes[7] = i_cfg.end_byte;
                o_burst.count    = CNT_W'(8);
                o_burst.has_end  = 1'b1;
                n_crc  = CRC_INIT;
                n_left = '0;
                n_open = 1'b0;
            end else begin
                o_burst.count = CNT_W'(5);
                n_crc  = w_crc_hdr;
                n_left = w_len[LEN_WIDTH-1:0];
                n_open = 1'b1;
            end
        end else if (r_open) begin
            o_burst.bytes[0] = i_data_byte;
            if (w_left_dec == '0) begin
                // last payload byte closes the frame
                o_burst.bytes[1] = w_crc_dat[15:8];
                o_burst.bytes[2] = w_crc_dat[7:0];
                o_burst.bytes[3] = i_cfg.end_byte;
                o_burst.count    = CNT_W'(4);
                o_burst.has_end  = 1'b1;
                n_crc  = CRC_INIT;
                n_left = '0;
                n_open = 1'b0;
            end else begin
                o_burst.count = CNT_W'(1);
                n_crc  = w_crc_dat;
                n_left = w_left_dec;
            end
        end
        // data with no open frame: empty burst, word dropped
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_left <= '0;
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_crc  <= n_crc;
            r_left <= n_left;
            r_open <= n_open;
        end
    end

endmodule

FILE: design/sfb_serializer.sv
module sfb_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  sfb_pkg::t_burst i_burst,
    input  logic            i_out_ready,
    output logic            o_load_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_frame_end
);
    import sfb_pkg::*;

    logic [MAX_BURST-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]          r_count;
    logic                      r_has_end;
    logic                      w_last;
    logic                      w_pop;

    assign w_last       = (r_count == CNT_W'(1));
    assign w_pop        = o_out_valid && i_out_ready;
    assign o_out_valid  = (r_count != '0);
    assign o_out_byte   = r_bytes[0];
    assign o_run_last   = w_last;
    assign o_frame_end  = r_has_end && w_last;
    // Take a new burst once the current one is empty or leaving now
    assign o_load_ready = (r_count == '0) || (w_last && i_out_ready);

    // Byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_load) begin
            r_count <= i_burst.count;
        end else if (w_pop) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Byte shift line
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes   <= i_burst.bytes;
            r_has_end <= i_burst.has_end;
        end else if (w_pop) begin
            r_bytes   <= r_bytes >> 8;
        end
    end

endmodule

FILE: design/sync_stx_frame_builder_crc16.sv
// Channel  Handshake                  Word
// -------  -------------------------  ------------------------------------------
// in       i_in_valid / o_in_ready    i_cmd, i_msg_code, i_payload_len, i_data_byte
// out      o_out_valid / i_out_ready  o_out_byte, o_run_last, o_frame_end
// cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An input word is framed combinationally into a burst of 0 to 8 bytes loaded
// into a shift line; the burst then leaves one byte per cycle while i_out_ready
// is high. A new input word is taken while the last byte of the previous burst
// leaves, so payload words run at one per cycle when the output does not stall;
// a start word yields 5 bytes (8 for an empty payload), the closing payload word 4.
// Reset (synchronous, active low) closes any frame and empties the output.
module sync_stx_frame_builder_crc16 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [7:0]                    i_msg_code,
    input  logic [15:0]                   i_payload_len,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_frame_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import sfb_pkg::*;

    t_cfg   w_cfg;
    t_burst w_burst;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    sfb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    sfb_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_cmd         (i_cmd),
        .i_msg_code    (i_msg_code),
        .i_payload_len (i_payload_len),
        .i_data_byte   (i_data_byte),
        .i_cfg         (w_cfg),
        .o_burst       (w_burst)
    );

    sfb_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_burst      (w_burst),
        .i_out_ready  (i_out_ready),
        .o_load_ready (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_frame_end  (o_frame_end)
    );

    // End byte is always the last byte of its burst
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_run_last)
        else $error("frame end byte not last of burst");

    // A start word always yields a header of several bytes, led by the sync byte
    a_start_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_START)) |=>
            (o_out_valid && !o_run_last && !o_frame_end
             && (o_out_byte == $past(w_cfg.sync_byte))))
        else $error("start word did not open a header burst");

    // A burst keeps going until its last byte leaves
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_run_last) |=> o_out_valid)
        else $error("burst ended early");

endmodule
